// ----- rtl/core/spk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spk_pkg;

  // Cipher geometry
  localparam int WORD_W      = 32;
  localparam int ROUND_COUNT = 26;
  localparam int ROUND_W     = $clog2(ROUND_COUNT);
  localparam int BLOCK_BYTES = 8;
  localparam int COUNT_W     = 4;
  localparam int ROT_X       = 8;
  localparam int ROT_Y       = 3;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd4;

  // Item queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef struct packed {
    logic [WORD_W-1:0] key0;
    logic [WORD_W-1:0] key1;
    logic [WORD_W-1:0] key2;
    logic [WORD_W-1:0] nonce_lo;
    logic [WORD_W-1:0] nonce_hi;
  } cfg_t;

  // Classified block as it sits in the queue
  typedef struct packed {
    logic [WORD_W-1:0]      data_low;
    logic [WORD_W-1:0]      data_high;
    logic [BLOCK_BYTES-1:0] byte_en;
    logic                   full;
    logic                   first;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } pair_t;

  // One Speck round: x = (x >>> 8) + y ^ k; y = (y <<< 3) ^ x
  function automatic pair_t speck_rnd(input logic [WORD_W-1:0] x,
                                      input logic [WORD_W-1:0] y,
                                      input logic [WORD_W-1:0] k);
    pair_t             r;
    logic [WORD_W-1:0] xn;
    xn  = ({x[ROT_X-1:0], x[WORD_W-1:ROT_X]} + y) ^ k;
    r.x = xn;
    r.y = {y[WORD_W-ROT_Y-1:0], y[WORD_W-1:WORD_W-ROT_Y]} ^ xn;
    return r;
  endfunction

  // Widen per-byte enables of one word into a bit mask
  function automatic logic [WORD_W-1:0] byte_mask(input logic [WORD_W/8-1:0] en);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W / 8; i++) begin
      m[i*8 +: 8] = {8{en[i]}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/spk_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input block channel
interface spk_in_if;
  logic                                valid;
  logic                                ready;
  logic [spk_pkg::WORD_W-1:0]          data_low;
  logic [spk_pkg::WORD_W-1:0]          data_high;
  logic [spk_pkg::COUNT_W-1:0]         byte_count;
  logic                                first_block;

  modport source (output valid, data_low, data_high, byte_count, first_block,
                  input ready);
  modport sink   (input valid, data_low, data_high, byte_count, first_block,
                  output ready);
endinterface

// Result block channel
interface spk_out_if;
  logic                       valid;
  logic                       ready;
  logic [spk_pkg::WORD_W-1:0] result_low;
  logic [spk_pkg::WORD_W-1:0] result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink   (input valid, result_low, result_high, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/speck64_96_ctr_keystream_xor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each block from the queue runs through the encryption rounds; a block that
//   starts a message first runs the key schedule into the key RAM.
// The back end takes a new block only after the last result is loaded for output;
//   the encryption round unit does one Speck round per cycle from the key RAM.
// Reset (rst_ni, async low) clears the config registers and counter to zero and
//   empties the queue; round keys stay unknown until a first block.

module speck64_96_ctr_keystream_xor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [spk_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [spk_pkg::WORD_W-1:0]      cfg_data_i,
  spk_in_if.sink                               in_i,
  spk_out_if.source                            out_o
);

  spk_pkg::cfg_t  cfg_q;
  logic           item_valid;
  spk_pkg::item_t item;
  logic           item_pop;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spk_pkg::REG_KEY0:     cfg_q.key0     <= cfg_data_i;
        spk_pkg::REG_KEY1:     cfg_q.key1     <= cfg_data_i;
        spk_pkg::REG_KEY2:     cfg_q.key2     <= cfg_data_i;
        spk_pkg::REG_NONCE_LO: cfg_q.nonce_lo <= cfg_data_i;
        spk_pkg::REG_NONCE_HI: cfg_q.nonce_hi <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  spk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  spk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/spk_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/spk_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spk_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  spk_in_if.sink          in_i,
  output logic            item_valid_o,
  output spk_pkg::item_t  item_o,
  input  wire logic       item_pop_i
);

  spk_pkg::item_t                    q_mem_q [spk_pkg::Q_DEPTH];
  logic [spk_pkg::Q_PTR_W-1:0]       wptr_q, wptr_d;
  logic [spk_pkg::Q_PTR_W-1:0]       rptr_q, rptr_d;
  logic [spk_pkg::Q_CNT_W-1:0]       cnt_q, cnt_d;
  logic                              push;
  logic                              pop;
  logic [spk_pkg::COUNT_W-1:0]       cnt_clamp;
  spk_pkg::item_t                    cls;

  assign in_i.ready   = (cnt_q < spk_pkg::Q_CNT_W'(spk_pkg::Q_DEPTH));
  assign push         = in_i.valid & in_i.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i & item_valid_o;
  assign item_o       = q_mem_q[rptr_q];

  // Classify: clamp the count, derive byte enables and the full-block flag
  always_comb begin
    cnt_clamp = (in_i.byte_count > spk_pkg::COUNT_W'(spk_pkg::BLOCK_BYTES))
              ? spk_pkg::COUNT_W'(spk_pkg::BLOCK_BYTES) : in_i.byte_count;
    cls.data_low  = in_i.data_low;
    cls.data_high = in_i.data_high;
    for (int i = 0; i < spk_pkg::BLOCK_BYTES; i++) begin
      cls.byte_en[i] = (spk_pkg::COUNT_W'(i) < cnt_clamp);
    end
    cls.full  = (cnt_clamp == spk_pkg::COUNT_W'(spk_pkg::BLOCK_BYTES));
    cls.first = in_i.first_block;
  end

  // Advance queue pointers
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == spk_pkg::Q_PTR_W'(spk_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == spk_pkg::Q_PTR_W'(spk_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the classified block
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spk_pkg::Q_CNT_W'(spk_pkg::Q_DEPTH))
    else $error("queue fill above depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill did not follow a transfer");

endmodule

`default_nettype wire

// ----- rtl/core/spk_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spk_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire spk_pkg::cfg_t  cfg_i,
  input  wire logic           item_valid_i,
  input  wire spk_pkg::item_t item_i,
  output logic                item_pop_o,
  spk_out_if.source           out_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_ROUND  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [spk_pkg::ROUND_W-1:0] LAST_RND =
    spk_pkg::ROUND_W'(spk_pkg::ROUND_COUNT - 1);

  logic [2:0]                   state_q, state_d;
  logic [spk_pkg::ROUND_W-1:0]  rnd_q, rnd_d;
  logic [spk_pkg::WORD_W-1:0]   ctr_q, ctr_d;
  logic [spk_pkg::WORD_W-1:0]   a_q, a_d, b_q, b_d, c_q, c_d;
  logic [spk_pkg::WORD_W-1:0]   x_q, x_d, y_q, y_d;
  spk_pkg::item_t               cur_q, cur_d;
  logic                         ovld_q, ovld_d;
  logic [spk_pkg::WORD_W-1:0]   olow_q, olow_d, ohigh_q, ohigh_d;
  logic                         rk_we;
  logic [spk_pkg::ROUND_W-1:0]  rk_raddr;
  logic [spk_pkg::WORD_W-1:0]   rk_rdata;
  spk_pkg::pair_t               kx_rnd;
  spk_pkg::pair_t               enc_rnd;
  logic                         out_free;

  // Round key store, written during expansion, read one key per round
  spk_ram #(
    .WIDTH (spk_pkg::WORD_W),
    .DEPTH (spk_pkg::ROUND_COUNT)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (rk_we),
    .waddr_i (rnd_q),
    .wdata_i (a_q),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  assign out_free = !ovld_q || out_o.ready;

  // Separate round units for key schedule and for encryption
  assign kx_rnd  = spk_pkg::speck_rnd(rnd_q[0] ? c_q : b_q, a_q,
                                      spk_pkg::WORD_W'(rnd_q));
  assign enc_rnd = spk_pkg::speck_rnd(x_q, y_q, rk_rdata);

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    ctr_d      = ctr_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    x_d        = x_q;
    y_d        = y_q;
    cur_d      = cur_q;
    ovld_d     = ovld_q;
    olow_d     = olow_q;
    ohigh_d    = ohigh_q;
    item_pop_o = 1'b0;
    rk_we      = 1'b0;
    rk_raddr   = '0;

    // Drop the result once it transfers
    if (ovld_q && out_o.ready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          rnd_d      = '0;
          if (item_i.first) begin
            a_d     = cfg_i.key0;
            b_d     = cfg_i.key1;
            c_d     = cfg_i.key2;
            ctr_d   = cfg_i.nonce_lo;
            state_d = ST_EXPAND;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_EXPAND: begin
        rk_we = 1'b1;
        a_d   = kx_rnd.y;
        if (rnd_q[0]) begin
          c_d = kx_rnd.x;
        end else begin
          b_d = kx_rnd.x;
        end
        if (rnd_q == LAST_RND) begin
          rnd_d   = '0;
          state_d = ST_PREP;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end
      ST_PREP: begin
        // Fetch the first round key, load the counter block
        rk_raddr = '0;
        x_d      = cfg_i.nonce_hi;
        y_d      = ctr_q;
        rnd_d    = '0;
        state_d  = ST_ROUND;
      end
      ST_ROUND: begin
        x_d = enc_rnd.x;
        y_d = enc_rnd.y;
        if (rnd_q == LAST_RND) begin
          state_d = ST_DONE;
        end else begin
          rk_raddr = rnd_q + 1'b1;
          rnd_d    = rnd_q + 1'b1;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          ovld_d  = 1'b1;
          olow_d  = (cur_q.data_low ^ y_q)
                  & spk_pkg::byte_mask(cur_q.byte_en[3:0]);
          ohigh_d = (cur_q.data_high ^ x_q)
                  & spk_pkg::byte_mask(cur_q.byte_en[7:4]);
          if (cur_q.full) begin
            ctr_d = ctr_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      ctr_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      ctr_q   <= ctr_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    x_q     <= x_d;
    y_q     <= y_d;
    cur_q   <= cur_d;
    olow_q  <= olow_d;
    ohigh_q <= ohigh_d;
  end

  assign out_o.valid       = ovld_q;
  assign out_o.result_low  = olow_q;
  assign out_o.result_high = ohigh_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (state_q == ST_IDLE) && item_valid_i)
    else $error("item taken outside idle");

  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= LAST_RND)
    else $error("round index out of range");

  a_ctr_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ctr_q) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_DONE))
    else $error("counter moved mid-block");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> ovld_q && (state_q == ST_IDLE))
    else $error("result not loaded at end of block");

endmodule

`default_nettype wire

// ----- sim/speck64_96_ctr_keystream_xor_checker.sv -----
`timescale 1ns / 1ps

module speck64_96_ctr_keystream_xor_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [spk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [spk_pkg::WORD_W-1:0]    cfg_data_i,
  spk_in_if                                  in_i,
  spk_out_if                                 res_i,
  output int                                 err_cnt_o,
  output int                                 pending_o
);

  import spk_pkg::*;

  localparam int WORD_BYTES = WORD_W / 8;
  localparam int REPORT_MAX = 10;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } word_pair_t;

  typedef struct packed {
    word_t lo;
    word_t hi;
  } cipher_blk_t;

  // Shadow of the register file and the cipher state
  word_t key_reg [3];
  word_t nonce_lo_reg;
  word_t nonce_hi_reg;
  word_t ctr;
  word_t rk [ROUND_COUNT];

  // Ciphertext blocks predicted but not yet seen on the result channel
  cipher_blk_t cipher_q [$];
  int          mismatches;

  // One round: rotate x right, add y, mix key; rotate y left, fold in x
  function automatic word_pair_t cipher_round(input word_t x, input word_t y, input word_t k);
    word_pair_t p;
    p.x = (((x >> ROT_X) | (x << (WORD_W - ROT_X))) + y) ^ k;
    p.y = ((y << ROT_Y) | (y >> (WORD_W - ROT_Y))) ^ p.x;
    return p;
  endfunction

  // Key schedule: the round index acts as the key of the schedule round
  function automatic void expand_schedule();
    word_t      a;
    word_t      b;
    word_t      c;
    word_pair_t p;
    a = key_reg[0];
    b = key_reg[1];
    c = key_reg[2];
    for (int i = 0; i < ROUND_COUNT; i++) begin
      rk[i] = a;
      if (i % 2 == 0) begin
        p = cipher_round(b, a, word_t'(i));
        b = p.x;
      end else begin
        p = cipher_round(c, a, word_t'(i));
        c = p.x;
      end
      a = p.y;
    end
  endfunction

  // Keep the low n bytes of a word
  function automatic word_t lane_mask(input int n);
    if (n <= 0) return '0;
    if (n >= WORD_BYTES) return '1;
    return {WORD_W{1'b1}} >> (8 * (WORD_BYTES - n));
  endfunction

  // Encrypt the counter block, xor onto the data, advance on full blocks
  function automatic cipher_blk_t predict_block(input word_t lo, input word_t hi,
                                                input logic [COUNT_W-1:0] cnt,
                                                input logic first);
    cipher_blk_t r;
    word_pair_t  p;
    int          n;
    n = (cnt > BLOCK_BYTES) ? BLOCK_BYTES : int'(cnt);
    if (first) begin
      expand_schedule();
      ctr = nonce_lo_reg;
    end
    p.x = nonce_hi_reg;
    p.y = ctr;
    for (int i = 0; i < ROUND_COUNT; i++) begin
      p = cipher_round(p.x, p.y, rk[i]);
    end
    r.lo = (lo ^ p.y) & lane_mask(n);
    r.hi = (hi ^ p.x) & lane_mask(n > WORD_BYTES ? n - WORD_BYTES : 0);
    if (n == BLOCK_BYTES) ctr = ctr + 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_blk_t want;
    if (!rst_ni) begin
      key_reg      = '{default: '0};
      nonce_lo_reg = '0;
      nonce_hi_reg = '0;
      ctr          = '0;
      rk           = '{default: '0};
      cipher_q.delete();
      mismatches   = 0;
      err_cnt_o   <= 0;
      pending_o   <= 0;
    end else begin
      // Track register writes; unmapped indexes fall through
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY0:     key_reg[0]   = cfg_data_i;
          REG_KEY1:     key_reg[1]   = cfg_data_i;
          REG_KEY2:     key_reg[2]   = cfg_data_i;
          REG_NONCE_LO: nonce_lo_reg = cfg_data_i;
          REG_NONCE_HI: nonce_hi_reg = cfg_data_i;
          default: ;
        endcase
      end

      // Compare a result transfer against the oldest prediction
      if (res_i.valid && res_i.ready) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result with nothing outstanding: low %h high %h",
                     $realtime, res_i.result_low, res_i.result_high);
        end else begin
          want = cipher_q.pop_front();
          if (res_i.result_low !== want.lo || res_i.result_high !== want.hi) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: result mismatch: expected low %h high %h, got low %h high %h",
                       $realtime, want.lo, want.hi, res_i.result_low, res_i.result_high);
          end
        end
      end

      // Predict each input transfer
      if (in_i.valid && in_i.ready) begin
        cipher_q.push_back(predict_block(in_i.data_low, in_i.data_high,
                                         in_i.byte_count, in_i.first_block));
      end

      err_cnt_o <= mismatches;
      pending_o <= cipher_q.size();
    end
  end

endmodule

// ----- sim/speck64_96_ctr_keystream_xor_tb.sv -----
`timescale 1ns / 1ps

module speck64_96_ctr_keystream_xor_tb;

  import spk_pkg::*;

  localparam int TOTAL_BLOCKS  = 1970;
  localparam int QUIET_FROM    = 1750;
  localparam int DRAIN_SLACK   = 80;
  localparam int TIMEOUT_NS    = 1_200_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0]    cfg_data;
  int                   err_cnt;
  int                   pending;

  bit idle_on;
  bit stall_on;
  int blocks_sent;
  int phase_end;

  spk_in_if  blk_in ();
  spk_out_if blk_out ();

  speck64_96_ctr_keystream_xor dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (blk_in),
    .out_o      (blk_out)
  );

  speck64_96_ctr_keystream_xor_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (blk_in),
    .res_i      (blk_out),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: stall in short bursts while enabled
  initial begin
    blk_out.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 3) == 0) begin
        blk_out.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      blk_out.ready <= 1'b1;
    end
  end

  // Mostly random words, with the all-zero and all-one extremes now and then
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] n_lo,
                           input logic [WORD_W-1:0] n_hi);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_NONCE_LO, n_lo);
    write_reg(REG_NONCE_HI, n_hi);
  endtask

  // Drop valid and hold until every predicted block has come back
  task automatic drain();
    blk_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Present one block and hold it until the transfer; valid stays high after
  task automatic send_block(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                            input logic [COUNT_W-1:0] cnt, input logic first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      blk_in.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    blk_in.valid       <= 1'b1;
    blk_in.data_low    <= lo;
    blk_in.data_high   <= hi;
    blk_in.byte_count  <= cnt;
    blk_in.first_block <= first;
    @(posedge clk);
    while (!blk_in.ready) @(posedge clk);
    blocks_sent++;
  endtask

  // Change one register between blocks of a running message
  task automatic mid_message_write();
    drain();
    case ($urandom_range(0, 4))
      0:       write_reg(REG_KEY0, rand_word());
      1:       write_reg(REG_KEY1, rand_word());
      2:       write_reg(REG_KEY2, rand_word());
      3:       write_reg(REG_NONCE_LO, rand_word());
      default: write_reg(REG_NONCE_HI, rand_word());
    endcase
  endtask

  // First block, run of full blocks, optional partial tail, rare stray blocks
  task automatic send_message();
    int n_full;
    if (blocks_sent >= QUIET_FROM) begin
      idle_on  = 1'b0;
      stall_on = 1'b0;
    end
    n_full = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
    send_block(rand_word(), rand_word(),
               ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(1, 7))
                                           : COUNT_W'(BLOCK_BYTES), 1'b1);
    for (int i = 0; i < n_full; i++) begin
      if ($urandom_range(0, 24) == 0) mid_message_write();
      send_block(rand_word(), rand_word(), COUNT_W'(BLOCK_BYTES), 1'b0);
    end
    if ($urandom_range(0, 1) == 1)
      send_block(rand_word(), rand_word(), COUNT_W'($urandom_range(1, 7)), 1'b0);
    // Broken sequence: keep going past the end without a new first block
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        send_block(rand_word(), rand_word(), COUNT_W'($urandom_range(1, 8)), 1'b0);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_KEY0;
    cfg_data          <= '0;
    blk_in.valid      <= 1'b0;
    blk_in.data_low   <= '0;
    blk_in.data_high  <= '0;
    blk_in.byte_count <= COUNT_W'(BLOCK_BYTES);
    blk_in.first_block <= 1'b0;
    idle_on            = 1'b0;
    stall_on           = 1'b0;
    blocks_sent        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Known key, counter two steps below the wrap
    write_all(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'hFFFF_FFFE, 32'h7461_4620);
    send_block('0, '0, COUNT_W'(BLOCK_BYTES), 1'b1);
    send_block('1, '1, COUNT_W'(BLOCK_BYTES), 1'b0);
    send_block('0, '0, COUNT_W'(BLOCK_BYTES), 1'b0);
    // Partial blocks of every size reuse the held counter
    for (int c = 1; c < BLOCK_BYTES; c++)
      send_block(rand_word(), rand_word(), COUNT_W'(c), 1'b0);
    send_block(32'hA5A5_A5A5, 32'h5A5A_5A5A, COUNT_W'(BLOCK_BYTES), 1'b0);
    send_block($urandom, $urandom, COUNT_W'(4), 1'b1);
    send_block($urandom, $urandom, COUNT_W'(BLOCK_BYTES), 1'b0);
    drain();

    // All-ones registers; a write to an unmapped index must change nothing
    write_all('1, '1, '1, '1, '1);
    write_reg(REG_SPARE, 32'h1234_5678);
    send_block('1, '1, COUNT_W'(BLOCK_BYTES), 1'b1);
    send_block('0, '0, COUNT_W'(5), 1'b0);
    drain();

    // Mid-message writes: keys wait for the next first block, upper nonce is live
    write_reg(REG_NONCE_HI, '0);
    write_reg(REG_KEY1, '0);
    write_reg(REG_NONCE_LO, 32'h0000_1000);
    send_block($urandom, $urandom, COUNT_W'(BLOCK_BYTES), 1'b0);
    drain();

    // All-zero registers
    write_all('0, '0, '0, '0, '0);
    send_block('0, '0, COUNT_W'(BLOCK_BYTES), 1'b1);
    send_block('0, '1, COUNT_W'(3), 1'b0);

    // Random phases, each behind a fresh configuration
    while (blocks_sent < TOTAL_BLOCKS) begin
      drain();
      case ($urandom_range(0, 5))
        0:       write_all('1, '1, '1, 32'hFFFF_FFFF - $urandom_range(0, 8), '1);
        1:       write_all('0, '0, '0, '0, '0);
        2:       write_all($urandom, $urandom, $urandom,
                           32'hFFFF_FFFF - $urandom_range(0, 8), $urandom);
        default: write_all(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom);
      idle_on   = (blocks_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      stall_on  = (blocks_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      phase_end = blocks_sent + $urandom_range(80, 200);
      while (blocks_sent < phase_end && blocks_sent < TOTAL_BLOCKS) send_message();
    end

    drain();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/spk_pkg.sv
rtl/core/spk_if.sv
rtl/core/spk_ram.sv
rtl/core/spk_front.sv
rtl/core/spk_back.sv
rtl/core/speck64_96_ctr_keystream_xor.sv
sim/speck64_96_ctr_keystream_xor_checker.sv
sim/speck64_96_ctr_keystream_xor_tb.sv
